>>> rtl/core/ldf_pkg.sv
// ----------------------------------------------------------------------------
// ldf_pkg
// Types and constants shared by the length-prefixed frame deframer modules.
// ----------------------------------------------------------------------------
package ldf_pkg;

    localparam int unsigned LEN_BITS = 24;
    localparam logic [7:0]  PCT_MOD  = 8'd101;

    typedef enum logic [1:0] {
        PH_HUNT    = 2'd0,
        PH_HEADER  = 2'd1,
        PH_PAYLOAD = 2'd2,
        PH_TRAILER = 2'd3
    } phase_t;

    typedef enum logic [1:0] {
        KIND_PAYLOAD = 2'd0,
        KIND_FRAME   = 2'd1,
        KIND_EOT     = 2'd2
    } kind_t;

    typedef struct packed {
        phase_t              phase;
        logic [1:0]          hdr_idx;
        logic [LEN_BITS-1:0] hdr_word;
        logic [LEN_BITS-1:0] remaining;
        logic                had_data;
        logic [6:0]          progress;
    } ldf_state_t;

    typedef struct packed {
        kind_t      kind;
        logic [7:0] data;
        logic       last;
    } ldf_result_t;

    // An 8-bit value is below 256, so at most two subtractions of the modulus.
    function automatic logic [6:0] pct_mod(input logic [7:0] v);
        logic [7:0] r;
        begin
            if (v >= 8'(2 * PCT_MOD))
            begin
                r = v - 8'(2 * PCT_MOD);
            end
            else if (v >= PCT_MOD)
            begin
                r = v - PCT_MOD;
            end
            else
            begin
                r = v;
            end
            return r[6:0];
        end
    endfunction

endpackage

>>> rtl/core/ldf_step.sv
// ----------------------------------------------------------------------------
// ldf_step
// Next-state and result logic for one received byte of the deframer.
// ----------------------------------------------------------------------------
module ldf_step
    import ldf_pkg::*;
(
    input  ldf_state_t  cur,
    input  logic [7:0]  rx_byte,
    input  logic [7:0]  delimiter,
    output ldf_state_t  nxt,
    output logic        emit,
    output ldf_result_t res
);

    logic [LEN_BITS-1:0] len;
    logic [LEN_BITS-1:0] rem_dec;

    assign len     = cur.hdr_word;
    assign rem_dec = cur.remaining - LEN_BITS'(1);

    always_comb
    begin
        nxt  = cur;
        emit = 1'b0;
        res  = '{kind: KIND_PAYLOAD, data: 8'd0, last: 1'b0};
        case (cur.phase)
            PH_HUNT:
            begin
                if (rx_byte == delimiter)
                begin
                    nxt.phase    = PH_HEADER;
                    nxt.hdr_idx  = 2'd0;
                    nxt.hdr_word = '0;
                end
            end
            PH_HEADER:
            begin
                case (cur.hdr_idx)
                    2'd0:    nxt.hdr_word[7:0]   = rx_byte;
                    2'd1:    nxt.hdr_word[15:8]  = rx_byte;
                    2'd2:    nxt.hdr_word[23:16] = rx_byte;
                    default: nxt.hdr_word        = cur.hdr_word;
                endcase
                if (cur.hdr_idx == 2'd3)
                begin
                    // The fourth byte is not stored in the header word; it sets the progress value.
                    nxt.progress  = pct_mod(rx_byte);
                    nxt.remaining = len;
                    nxt.had_data  = (len != '0);
                    nxt.hdr_idx   = 2'd0;
                    nxt.phase     = (len != '0) ? PH_PAYLOAD : PH_TRAILER;
                end
                else
                begin
                    nxt.hdr_idx = cur.hdr_idx + 2'd1;
                end
            end
            PH_PAYLOAD:
            begin
                emit          = 1'b1;
                res.data      = rx_byte;
                nxt.remaining = rem_dec;
                if (rem_dec == '0)
                begin
                    nxt.phase = PH_TRAILER;
                end
            end
            default:
            begin
                emit         = 1'b1;
                res.kind     = cur.had_data ? KIND_FRAME : KIND_EOT;
                res.last     = 1'b1;
                nxt.phase    = PH_HUNT;
                nxt.hdr_idx  = 2'd0;
                nxt.hdr_word = '0;
                nxt.had_data = 1'b0;
            end
        endcase
    end

endmodule

>>> rtl/core/length_prefixed_frame_deframer.sv
// ----------------------------------------------------------------------------
// length_prefixed_frame_deframer
// Hunts for a start byte, reads a four-byte header and streams the payload.
// ----------------------------------------------------------------------------
// The block takes one byte per cycle and produces at most one result per
// byte. Each byte updates the frame state, and any result lands in an
// output register on the edge that accepts the byte, so a result appears
// in the cycle after its byte is accepted. rx_ready stays high while the
// output register is empty or being drained; only a stalled output holds
// the input back. Header bytes and bytes seen while hunting produce no
// result. Progress carries the most recent header's top byte modulo 101.
module length_prefixed_frame_deframer
    import ldf_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [7:0] cfg_data,
    input  logic       rx_valid,
    output logic       rx_ready,
    input  logic [7:0] rx_byte,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [1:0] kind,
    output logic [7:0] data_out,
    output logic [6:0] progress,
    output logic       frame_last
);

    logic [7:0]  delim_reg;
    ldf_state_t  state_reg;
    ldf_state_t  state_next;
    logic        emit;
    ldf_result_t res;
    logic        out_valid_reg;
    ldf_result_t out_reg;
    logic [6:0]  out_pct_reg;
    logic        rx_take;

    assign cfg_ready = 1'b1;
    assign rx_ready  = !out_valid_reg || out_ready;
    assign rx_take   = rx_valid && rx_ready;

    ldf_step u_step (
        .cur       (state_reg),
        .rx_byte   (rx_byte),
        .delimiter (delim_reg),
        .nxt       (state_next),
        .emit      (emit),
        .res       (res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            delim_reg     <= 8'd0;
            state_reg     <= '{phase: PH_HUNT, default: '0};
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                delim_reg <= cfg_data;
            end
            if (rx_take)
            begin
                state_reg <= state_next;
            end
            if (rx_take && emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload of the output register; the progress value is the one in force
    // after this byte's update.
    always_ff @(posedge clk)
    begin
        if (rx_take && emit)
        begin
            out_reg     <= res;
            out_pct_reg <= state_next.progress;
        end
    end

    assign out_valid  = out_valid_reg;
    assign kind       = out_reg.kind;
    assign data_out   = out_reg.data;
    assign progress   = out_pct_reg;
    assign frame_last = out_reg.last;

endmodule

>>> rtl/core/ldf_checker.sv
// ----------------------------------------------------------------------------
// ldf_checker
// Port-level checks on the deframer results, bound to the top level.
// ----------------------------------------------------------------------------
module ldf_checker
    import ldf_pkg::*;
(
    input logic       clk,
    input logic       rst_n,
    input logic       out_valid,
    input logic       out_ready,
    input logic [1:0] kind,
    input logic [7:0] data_out,
    input logic [6:0] progress,
    input logic       frame_last
);

    // A closing result is never a payload byte, and a payload byte never closes.
    a_last_kind: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (frame_last == (kind != KIND_PAYLOAD)))
        else $error("frame_last does not match result kind");

    a_trailer_data: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && kind != KIND_PAYLOAD) |-> (data_out == 8'd0 &&
            (kind == KIND_FRAME || kind == KIND_EOT)))
        else $error("trailer result carries data or bad kind");

    a_pct_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (progress <= 7'd100))
        else $error("progress above 100");

    // A stalled request holds its payload.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(kind) &&
            $stable(data_out) && $stable(progress) && $stable(frame_last)))
        else $error("output request changed while stalled");

endmodule

bind length_prefixed_frame_deframer ldf_checker u_ldf_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .kind       (kind),
    .data_out   (data_out),
    .progress   (progress),
    .frame_last (frame_last)
);

>>> bench/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for length_prefixed_frame_deframer. Byte streams of
// framed and unframed traffic are sent under several start-byte settings,
// with random gaps on the input and random stalls on the output. Every
// output request is checked against a frame decoder kept alongside the block.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import ldf_pkg::*;

    localparam int WATCHDOG_LIMIT = 1000;

    typedef struct packed {
        kind_t      kind;
        logic [7:0] data;
        logic [6:0] pct;
        logic       last;
    } deframed_t;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       cfg_valid = 1'b0;
    logic       cfg_ready;
    logic [7:0] cfg_data = 8'h00;
    logic       rx_valid = 1'b0;
    logic       rx_ready;
    logic [7:0] rx_byte = 8'h00;
    logic       out_valid;
    logic       out_ready = 1'b0;
    logic [1:0] kind;
    logic [7:0] data_out;
    logic [6:0] progress;
    logic       frame_last;

    // Decoder state, mirroring what the block keeps.
    logic [7:0]  frame_delim = 8'h00;
    phase_t      dec_phase = PH_HUNT;
    logic [1:0]  dec_hdr_idx = 2'd0;
    logic [31:0] dec_hdr_word = 32'd0;
    logic [23:0] dec_remaining = 24'd0;
    logic        dec_had_data = 1'b0;
    logic [6:0]  dec_pct = 7'd0;

    logic [7:0] stream_bytes[$];
    deframed_t  pending_deframed[$];

    logic rx_accepted = 1'b0;
    int   rx_gap = 0;
    int   rx_calm = 0;
    int   out_hold = 0;
    int   out_calm = 0;
    int   idle_cycles = 0;
    int   mismatch_count = 0;

    length_prefixed_frame_deframer dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_data   (cfg_data),
        .rx_valid   (rx_valid),
        .rx_ready   (rx_ready),
        .rx_byte    (rx_byte),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .kind       (kind),
        .data_out   (data_out),
        .progress   (progress),
        .frame_last (frame_last)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Mostly short gaps, now and then a long one.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
        begin
            return 0;
        end
        else if (r < 92)
        begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(4, 24);
    endfunction

    task automatic deframe_byte(input logic [7:0] b);
        deframed_t   res;
        logic [23:0] len;
        begin
            case (dec_phase)
                PH_HUNT:
                begin
                    if (b == frame_delim)
                    begin
                        dec_phase = PH_HEADER;
                        dec_hdr_idx = 2'd0;
                        dec_hdr_word = 32'd0;
                    end
                end
                PH_HEADER:
                begin
                    dec_hdr_word = dec_hdr_word | (32'(b) << (8 * dec_hdr_idx));
                    if (dec_hdr_idx == 2'd3)
                    begin
                        len = dec_hdr_word[23:0];
                        dec_pct = 7'(int'(dec_hdr_word[31:24]) % 101);
                        dec_remaining = len;
                        dec_had_data = (len != 24'd0);
                        dec_hdr_idx = 2'd0;
                        dec_phase = (len != 24'd0) ? PH_PAYLOAD : PH_TRAILER;
                    end
                    else
                    begin
                        dec_hdr_idx = dec_hdr_idx + 2'd1;
                    end
                end
                PH_PAYLOAD:
                begin
                    res = '{kind: KIND_PAYLOAD, data: b, pct: dec_pct, last: 1'b0};
                    pending_deframed.push_back(res);
                    dec_remaining = dec_remaining - 24'd1;
                    if (dec_remaining == 24'd0)
                    begin
                        dec_phase = PH_TRAILER;
                    end
                end
                default:
                begin
                    // The trailer closes the frame whatever its value.
                    res = '{kind: dec_had_data ? KIND_FRAME : KIND_EOT, data: 8'h00,
                            pct: dec_pct, last: 1'b1};
                    pending_deframed.push_back(res);
                    dec_phase = PH_HUNT;
                    dec_hdr_idx = 2'd0;
                    dec_hdr_word = 32'd0;
                    dec_had_data = 1'b0;
                end
            endcase
        end
    endtask

    task automatic check_output();
        deframed_t want;
        begin
            if (pending_deframed.size() == 0)
            begin
                if (mismatch_count < 10)
                begin
                    $display("tb: unexpected output kind=%0d data=%02h pct=%0d last=%0b",
                             kind, data_out, progress, frame_last);
                end
                mismatch_count = mismatch_count + 1;
            end
            else
            begin
                want = pending_deframed.pop_front();
                if (kind !== want.kind || data_out !== want.data
                    || progress !== want.pct || frame_last !== want.last)
                begin
                    if (mismatch_count < 10)
                    begin
                        $display({"tb: mismatch exp kind=%0d data=%02h pct=%0d last=%0b,",
                                  " got kind=%0d data=%02h pct=%0d last=%0b"},
                                 want.kind, want.data, want.pct, want.last,
                                 kind, data_out, progress, frame_last);
                    end
                    mismatch_count = mismatch_count + 1;
                end
            end
        end
    endtask

    // Monitor: decodes accepted bytes, checks accepted outputs, runs the watchdog.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (rx_valid && rx_ready)
            begin
                deframe_byte(rx_byte);
            end
            if (out_valid && out_ready)
            begin
                check_output();
            end
            if ((rx_valid && rx_ready) || (out_valid && out_ready)
                || (cfg_valid && cfg_ready))
            begin
                idle_cycles = 0;
            end
            else
            begin
                idle_cycles = idle_cycles + 1;
            end
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("tb: done, errors");
                $finish;
            end
        end
        rx_accepted <= rst_n && rx_valid && rx_ready;
    end

    // Byte driver: holds each request until it is taken, then waits out a gap.
    always @(negedge clk)
    begin
        if (!rx_valid || rx_accepted)
        begin
            if (rx_gap > 0)
            begin
                rx_gap = rx_gap - 1;
                rx_valid <= 1'b0;
            end
            else if (stream_bytes.size() != 0)
            begin
                rx_byte <= stream_bytes.pop_front();
                rx_valid <= 1'b1;
                if (rx_calm > 0)
                begin
                    rx_calm = rx_calm - 1;
                    rx_gap = 0;
                end
                else
                begin
                    if ($urandom_range(0, 99) == 0)
                    begin
                        rx_calm = $urandom_range(20, 100);
                    end
                    rx_gap = pick_gap();
                end
            end
            else
            begin
                rx_valid <= 1'b0;
            end
        end
    end

    always @(negedge clk)
    begin
        if (out_hold > 0)
        begin
            out_hold = out_hold - 1;
            out_ready <= 1'b0;
        end
        else
        begin
            out_ready <= 1'b1;
            if (out_calm > 0)
            begin
                out_calm = out_calm - 1;
            end
            else if ($urandom_range(0, 99) == 0)
            begin
                out_calm = $urandom_range(20, 100);
            end
            else if ($urandom_range(0, 99) < 25)
            begin
                out_hold = pick_gap();
            end
        end
    end

    task automatic write_delimiter(input logic [7:0] value);
        begin
            @(negedge clk);
            cfg_data <= value;
            cfg_valid <= 1'b1;
            do
            begin
                @(posedge clk);
            end
            while (!cfg_ready);
            frame_delim = value;
            @(negedge clk);
            cfg_valid <= 1'b0;
        end
    endtask

    // Waits until every byte is taken and every output has come, plus a margin
    // for a header byte still being absorbed.
    task automatic wait_until_drained();
        begin
            do
            begin
                @(posedge clk);
            end
            while (stream_bytes.size() != 0 || rx_valid || pending_deframed.size() != 0);
            repeat (4) @(posedge clk);
        end
    endtask

    task automatic queue_frame(input logic [23:0] len, input logic [7:0] top,
                               input int unsigned n_payload, input bit closed);
        int unsigned i;
        begin
            stream_bytes.push_back(frame_delim);
            stream_bytes.push_back(len[7:0]);
            stream_bytes.push_back(len[15:8]);
            stream_bytes.push_back(len[23:16]);
            stream_bytes.push_back(top);
            for (i = 0; i < n_payload; i++)
            begin
                stream_bytes.push_back(8'($urandom));
            end
            if (closed)
            begin
                stream_bytes.push_back(8'($urandom));
            end
        end
    endtask

    // Mostly well-formed frames; the rest is line noise that never matches
    // the start byte, so the decoder stays in step with the generator.
    task automatic queue_traffic(input int n_items);
        int         sent;
        int         r;
        int         k;
        logic [7:0] nb;
        logic [23:0] len;
        begin
            sent = 0;
            while (sent < n_items)
            begin
                r = $urandom_range(0, 99);
                if (r < 12)
                begin
                    k = $urandom_range(1, 8);
                    repeat (k)
                    begin
                        do
                        begin
                            nb = 8'($urandom);
                        end
                        while (nb == frame_delim);
                        stream_bytes.push_back(nb);
                    end
                    sent = sent + k;
                end
                else
                begin
                    r = $urandom_range(0, 99);
                    if (r < 12)
                    begin
                        len = 24'd0;
                    end
                    else if (r < 80)
                    begin
                        len = 24'($urandom_range(1, 6));
                    end
                    else if (r < 98)
                    begin
                        len = 24'($urandom_range(7, 40));
                    end
                    else
                    begin
                        len = 24'($urandom_range(256, 600));
                    end
                    queue_frame(len, 8'($urandom), 32'(len), 1'b1);
                    sent = sent + 6 + int'(len);
                end
            end
        end
    endtask

    initial
    begin
        logic [7:0] directed[23] = '{
            8'h55, 8'hFF,
            8'h00, 8'h01, 8'h00, 8'h00, 8'hFF, 8'hFF, 8'h00,
            8'h00, 8'h00, 8'h00, 8'h00, 8'h65, 8'hFF,
            8'h00, 8'h02, 8'h00, 8'h00, 8'h64, 8'h00, 8'h00, 8'hAA
        };
        logic [7:0] settings[5];

        settings = '{8'hFF, 8'h00, 8'($urandom), 8'h7E, 8'hA5};
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Reset start byte: noise, a one-byte frame, an end-of-transfer frame,
        // and a frame whose header and payload hold the start byte.
        foreach (directed[i])
        begin
            stream_bytes.push_back(directed[i]);
        end
        wait_until_drained();

        foreach (settings[p])
        begin
            write_delimiter(settings[p]);
            queue_traffic(220);
            if (p == 3)
            begin
                // Counter borrow across a length byte boundary.
                queue_frame(24'h000100, 8'($urandom), 256, 1'b1);
                queue_traffic(20);
            end
            wait_until_drained();
        end

        // A maximal length frame left open: the run stops partway through it.
        queue_frame(24'hFFFFFF, 8'hFF, 200, 1'b0);
        wait_until_drained();
        repeat (5) @(posedge clk);

        if (mismatch_count == 0 && pending_deframed.size() == 0)
        begin
            $display("tb: done, clean");
        end
        else
        begin
            $display("tb: done, errors");
        end
        $finish;
    end

endmodule
